/* src/istw_pkg.sv */
// ----------------------------------------------------------------------------
// istw_pkg
// Shared types, constants and codes of the tunneling instruction walker.
// ----------------------------------------------------------------------------
package istw_pkg;

  localparam int MaxLen     = 15;
  localparam int DepthLimit = 15;
  localparam int NumBytes   = 15;
  localparam int CfgIdxW    = 3;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CFG_FROZEN_LENGTH    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RANGE_LOW        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RANGE_HIGH       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WALK_DEPTH       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PREFIX_HEAD_LOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PREFIX_HEAD_HIGH = 3'd5;

  // item function codes
  localparam logic FUNC_OPEN = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef logic [NumBytes-1:0][7:0] cand_t;

  typedef struct packed {
    logic [3:0] frozen_length;
    logic [7:0] range_low;
    logic [7:0] range_high;
    logic [3:0] walk_depth;
    cand_t      prefix;       // bytes 0..14 of the frozen prefix
  } cfg_t;

  typedef struct packed {
    cand_t       cand;
    logic [63:0] visited;
    logic [63:0] skipped;
    logic        finished;
    logic [3:0]  fixed;       // frozen length latched at open
    logic [3:0]  depth;       // walk depth latched at open
    logic [7:0]  hi;          // range high latched at open
  } walk_t;

  typedef struct packed {
    logic        status;
    logic        more;
    logic [63:0] candidate_low;
    logic [55:0] candidate_high;
    logic [63:0] visited_total;
    logic [63:0] skipped_total;
  } result_t;

endpackage

/* src/istw_if.sv */
// ----------------------------------------------------------------------------
// istw interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface istw_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] bytes_consumed;

  modport source (output valid, output func, output bytes_consumed, input ready);
  modport sink   (input valid, input func, input bytes_consumed, output ready);
endinterface

interface istw_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        more;
  logic [63:0] candidate_low;
  logic [55:0] candidate_high;
  logic [63:0] visited_total;
  logic [63:0] skipped_total;

  modport source (output valid, output status, output more, output candidate_low,
                  output candidate_high, output visited_total, output skipped_total,
                  input ready);
  modport sink   (input valid, input status, input more, input candidate_low,
                  input candidate_high, input visited_total, input skipped_total,
                  output ready);
endinterface

interface istw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/istw_cfg.sv */
// ----------------------------------------------------------------------------
// istw_cfg
// Configuration register file; one write beat per cycle, always ready.
// ----------------------------------------------------------------------------
module istw_cfg
  import istw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  istw_cfg_if.sink cfg_i,
  output cfg_t cfg_o
);

  logic [3:0]  frozen_length_q;
  logic [7:0]  range_low_q;
  logic [7:0]  range_high_q;
  logic [3:0]  walk_depth_q;
  logic [63:0] prefix_low_q;
  logic [55:0] prefix_high_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frozen_length_q <= 4'd0;
      range_low_q     <= 8'd0;
      range_high_q    <= 8'hFF;
      walk_depth_q    <= 4'd1;
      prefix_low_q    <= 64'd0;
      prefix_high_q   <= 56'd0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FROZEN_LENGTH:    frozen_length_q <= cfg_i.data[3:0];
        CFG_RANGE_LOW:        range_low_q     <= cfg_i.data[7:0];
        CFG_RANGE_HIGH:       range_high_q    <= cfg_i.data[7:0];
        CFG_WALK_DEPTH:       walk_depth_q    <= cfg_i.data[3:0];
        CFG_PREFIX_HEAD_LOW:  prefix_low_q    <= cfg_i.data;
        CFG_PREFIX_HEAD_HIGH: prefix_high_q   <= cfg_i.data[55:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.frozen_length = frozen_length_q;
  assign cfg_o.range_low     = range_low_q;
  assign cfg_o.range_high    = range_high_q;
  assign cfg_o.walk_depth    = walk_depth_q;
  assign cfg_o.prefix        = {prefix_high_q, prefix_low_q};

endmodule

/* src/istw_step.sv */
// ----------------------------------------------------------------------------
// istw_step
// Next walk state and result for one item: open check/load, or one
// tunneling step (clamp, clear tail, carry increment, saturating skip count).
// ----------------------------------------------------------------------------
module istw_step
  import istw_pkg::*;
(
  input  cfg_t       cfg_i,
  input  walk_t      walk_i,
  input  logic       func_i,
  input  logic [7:0] bytes_consumed_i,
  output walk_t      walk_o,
  output result_t    result_o
);

  logic                invalid;
  logic [3:0]          point;
  logic [3:0]          skip_k;
  logic [63:0]         skip_add;
  logic [64:0]         skip_sum;
  logic [NumBytes-1:0] inc;
  logic                run;
  logic                carry_out;
  logic                done;
  cand_t               cand_n;

  always_comb begin
    invalid = (cfg_i.walk_depth == 4'd0)
           || (int'(cfg_i.walk_depth) > DepthLimit)
           || (int'(cfg_i.walk_depth) > MaxLen)
           || (cfg_i.frozen_length >= cfg_i.walk_depth)
           || (cfg_i.range_low > cfg_i.range_high);

    // increment point: clamp consumption to [1, depth], step back one,
    // never below the frozen head
    if (bytes_consumed_i < {4'd0, walk_i.depth}) point = bytes_consumed_i[3:0];
    else                                         point = walk_i.depth;
    if (point == 4'd0) point = 4'd1;
    point = point - 4'd1;
    if (point < walk_i.fixed) point = walk_i.fixed;

    // 256^k - 1 skipped below the point, all ones once k reaches 8
    skip_k = walk_i.depth - 4'd1 - point;
    if (skip_k[3]) skip_add = '1;
    else           skip_add = (64'd1 << {skip_k[2:0], 3'b000}) - 64'd1;
    skip_sum = {1'b0, walk_i.skipped} + {1'b0, skip_add};

    // byte j bumps when every byte above it up to the point is 0xFF
    cand_n = walk_i.cand;
    for (int j = 0; j < NumBytes; j++) begin
      run = 1'b1;
      for (int i = 0; i < NumBytes; i++) begin
        if (i > j && i <= int'(point) && walk_i.cand[i] != 8'hFF) run = 1'b0;
      end
      inc[j] = run && (j >= int'(walk_i.fixed)) && (j <= int'(point));
      if (inc[j])                                          cand_n[j] = walk_i.cand[j] + 8'd1;
      else if (j > int'(point) && j < int'(walk_i.depth)) cand_n[j] = 8'h00;
    end
    carry_out = inc[walk_i.fixed] && (walk_i.cand[walk_i.fixed] == 8'hFF);
    done      = carry_out || (cand_n[walk_i.fixed] > walk_i.hi);

    walk_o                  = walk_i;
    result_o.status         = STATUS_OK;
    result_o.more           = 1'b0;
    result_o.candidate_low  = 64'd0;
    result_o.candidate_high = 56'd0;
    result_o.visited_total  = walk_i.visited;
    result_o.skipped_total  = walk_i.skipped;

    if (func_i == FUNC_OPEN) begin
      if (invalid) begin
        result_o.status = STATUS_INVALID;
      end else begin
        for (int j = 0; j < NumBytes; j++) begin
          if (j == int'(cfg_i.frozen_length))     walk_o.cand[j] = cfg_i.range_low;
          else if (j < int'(cfg_i.frozen_length)) walk_o.cand[j] = cfg_i.prefix[j];
          else                                    walk_o.cand[j] = 8'h00;
        end
        walk_o.visited  = 64'd0;
        walk_o.skipped  = 64'd0;
        walk_o.finished = 1'b0;
        walk_o.fixed    = cfg_i.frozen_length;
        walk_o.depth    = cfg_i.walk_depth;
        walk_o.hi       = cfg_i.range_high;
        result_o.more           = 1'b1;
        result_o.candidate_low  = walk_o.cand[7:0];
        result_o.candidate_high = walk_o.cand[14:8];
        result_o.visited_total  = 64'd0;
        result_o.skipped_total  = 64'd0;
      end
    end else if (!walk_i.finished) begin
      walk_o.cand     = cand_n;
      walk_o.visited  = walk_i.visited + 64'd1;
      walk_o.skipped  = skip_sum[64] ? '1 : skip_sum[63:0];
      walk_o.finished = done;
      result_o.more          = !done;
      result_o.visited_total = walk_o.visited;
      result_o.skipped_total = walk_o.skipped;
      if (!done) begin
        result_o.candidate_low  = cand_n[7:0];
        result_o.candidate_high = cand_n[14:8];
      end
    end
  end

endmodule

/* src/instruction_space_tunnel_walker.sv */
// ----------------------------------------------------------------------------
// instruction_space_tunnel_walker
// Pipeline: an accepted input beat waits in the input slot, then its result is registered in the result register.
// Throughput: one item per cycle while the receiver takes results; the 15-byte carry
//   increment and the 64-bit saturating skip add both fit in the single step stage.
// Reset: async active low; no walk open, counters and candidate zero,
//   registers at their documented defaults, both pipeline slots empty.
// ----------------------------------------------------------------------------
module instruction_space_tunnel_walker
  import istw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  istw_in_if.sink    in_i,
  istw_cfg_if.sink   cfg_i,
  istw_out_if.source out_o
);

  cfg_t       cfg;
  walk_t      walk_q, walk_d;
  result_t    result_d, result_q;

  // input slot
  logic       in_valid_q;
  logic       func_q;
  logic [7:0] consumed_q;

  logic       out_valid_q;
  logic       out_free;
  logic       advance;

  istw_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Step logic sees the walk state left by the previous item, so items
  // retire strictly in order, one per cycle while the result register is free.
  istw_step u_step (
    .cfg_i            (cfg),
    .walk_i           (walk_q),
    .func_i           (func_q),
    .bytes_consumed_i (consumed_q),
    .walk_o           (walk_d),
    .result_o         (result_d)
  );

  // result register frees when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // input payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      func_q     <= in_i.func;
      consumed_q <= in_i.bytes_consumed;
    end
  end

  // walk state commits only when its item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q.cand     <= '0;
      walk_q.visited  <= 64'd0;
      walk_q.skipped  <= 64'd0;
      walk_q.finished <= 1'b1;
      walk_q.fixed    <= 4'd0;
      walk_q.depth    <= 4'd0;
      walk_q.hi       <= 8'd0;
    end else if (advance) begin
      walk_q <= walk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = result_q.status;
  assign out_o.more           = result_q.more;
  assign out_o.candidate_low  = result_q.candidate_low;
  assign out_o.candidate_high = result_q.candidate_high;
  assign out_o.visited_total  = result_q.visited_total;
  assign out_o.skipped_total  = result_q.skipped_total;

endmodule

/* src/istw_checker.sv */
// ----------------------------------------------------------------------------
// istw_checker
// Port-level checks on the walker's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module istw_checker
  import istw_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        status_i,
  input logic        more_i,
  input logic [63:0] candidate_low_i,
  input logic [55:0] candidate_high_i,
  input logic [63:0] visited_total_i,
  input logic [63:0] skipped_total_i
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // and its payload holds (status is not checked)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(candidate_low_i) && $stable(candidate_high_i)
      && $stable(visited_total_i) && $stable(skipped_total_i) && $stable(more_i))
    else $error("stalled result payload changed");

  // a rejected open never offers a candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_INVALID |-> !more_i)
    else $error("invalid open reported a candidate");

  // no candidate means all candidate bytes read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !more_i |-> candidate_low_i == 64'd0 && candidate_high_i == 56'd0)
    else $error("candidate bytes nonzero with walk finished");

endmodule

bind instruction_space_tunnel_walker istw_checker u_istw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .more_i           (out_o.more),
  .candidate_low_i  (out_o.candidate_low),
  .candidate_high_i (out_o.candidate_high),
  .visited_total_i  (out_o.visited_total),
  .skipped_total_i  (out_o.skipped_total)
);

/* tb/sv/instruction_space_tunnel_walker_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// instruction_space_tunnel_walker_test
// Self-checking bench for the tunneling walker. A behavioral predictor keeps
// its own copy of the registers and of the walk, works out the result of
// every accepted item beat and compares each result beat field by field.
// Directed tests cover the corner cases, then random walks with random
// back-pressure on both sides.
// ----------------------------------------------------------------------------
module instruction_space_tunnel_walker_test;
  import istw_pkg::*;

  localparam int ClkHalf     = 2;       // 4 ns period
  localparam int IdlePct     = 36;      // idle share of each side, percent
  localparam int HoldCycles  = 300;     // long receiver hold-off
  localparam int DrainCycles = 6;       // drain margin after the last result
  localparam int CycleLimit  = 400000;  // watchdog
  localparam int RandomItems = 700;     // items in random walks, on top of the rest

  logic clk_i;
  logic rst_ni;

  istw_in_if  in_if ();
  istw_cfg_if cfg_if ();
  istw_out_if out_if ();

  instruction_space_tunnel_walker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // --------------------------------------------------------------------------
  // Predictor state
  // --------------------------------------------------------------------------
  // shadow of the configuration registers
  logic [3:0]  reg_frozen;
  logic [7:0]  reg_low;
  logic [7:0]  reg_high;
  logic [3:0]  reg_depth;
  logic [63:0] reg_prefix_lo;
  logic [55:0] reg_prefix_hi;

  // shadow of the walk; settings are latched at open
  cand_t       walk_cand;
  logic [63:0] walk_visited;
  logic [63:0] walk_skipped;
  logic        walk_done;
  logic [3:0]  walk_fixed;
  logic [3:0]  walk_depth;
  logic [7:0]  walk_hi;

  // results still owed by the block, oldest first
  result_t     owed_results[$];

  // bookkeeping
  int n_items, n_results, n_rejected, n_ends, n_saturated, n_phases, n_fail;
  int cycles;
  bit no_idle;        // both sides stop idling
  bit hold_request;   // ask the receiver for one long hold-off
  bit in_live;        // item valid is currently driven high
  bit cfg_live;       // config valid is currently driven high

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // result beat from the current walk shadow; candidate reads zero when done
  function automatic result_t walk_beat(logic status, logic more);
    result_t      r;
    logic [119:0] flat;
    flat               = walk_cand;
    r.status           = status;
    r.more             = more;
    r.candidate_low    = more ? flat[63:0]   : 64'd0;
    r.candidate_high   = more ? flat[119:64] : 56'd0;
    r.visited_total    = walk_visited;
    r.skipped_total    = walk_skipped;
    return r;
  endfunction

  // applies one item to the walk shadow and returns the result it causes
  function automatic result_t next_walk_beat(logic func, logic [7:0] consumed);
    logic [119:0] prefix;
    logic [63:0]  skip;
    int           point, k, dep, fixed, j;
    bit           carry_out;
    prefix    = {reg_prefix_hi, reg_prefix_lo};
    carry_out = 1'b0;

    if (func == FUNC_OPEN) begin
      // a rejected open leaves any running walk untouched
      if (reg_depth == 0 || reg_depth > DepthLimit || reg_depth > MaxLen ||
          reg_frozen >= reg_depth || reg_low > reg_high) begin
        return walk_beat(STATUS_INVALID, 1'b0);
      end
      walk_cand = '0;
      for (j = 0; j < int'(reg_frozen); j++) begin
        walk_cand[j] = prefix[8*j +: 8];
      end
      walk_cand[reg_frozen] = reg_low;
      walk_fixed   = reg_frozen;
      walk_depth   = reg_depth;
      walk_hi      = reg_high;
      walk_visited = '0;
      walk_skipped = '0;
      walk_done    = 1'b0;
      return walk_beat(STATUS_OK, 1'b1);
    end

    // step with no walk open: nothing moves
    if (walk_done) begin
      return walk_beat(STATUS_OK, 1'b0);
    end

    dep   = int'(walk_depth);
    fixed = int'(walk_fixed);
    walk_visited = walk_visited + 64'd1;

    // clamp consumption to [1, depth], then never below the frozen head
    point = (int'(consumed) < dep) ? int'(consumed) : dep;
    if (point == 0) point = 1;
    point = point - 1;
    if (point < fixed) point = fixed;
    if (point >= NumBytes) point = NumBytes - 1;

    // tunneling skips 256^k - 1 candidates, all ones once k reaches 8
    k    = dep - 1 - point;
    skip = (k >= 8) ? '1 : ((64'd1 << (8 * k)) - 64'd1);
    walk_skipped = (walk_skipped > ~skip) ? '1 : walk_skipped + skip;

    for (j = point + 1; j < dep && j < NumBytes; j++) begin
      walk_cand[j] = 8'h00;
    end

    // increment with carry, stopping at the frozen head
    j = point;
    while (1) begin
      if (walk_cand[j] != 8'hFF) begin
        walk_cand[j] = walk_cand[j] + 8'd1;
        break;
      end
      walk_cand[j] = 8'h00;
      if (j <= fixed || j == 0) begin
        carry_out = 1'b1;
        break;
      end
      j = j - 1;
    end

    if (carry_out || walk_cand[fixed] > walk_hi) begin
      walk_done = 1'b1;
      return walk_beat(STATUS_OK, 1'b0);
    end
    return walk_beat(STATUS_OK, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still owed",
             cycles, owed_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int held;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        // hold ready low while the sender keeps offering; the block fills up
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every result beat against the oldest owed result
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (owed_results.size() == 0) begin
        $error("result beat arrived with nothing owed");
        n_fail++;
      end else begin
        want = owed_results.pop_front();
        check_field("status",         64'(want.status),         64'(out_if.status));
        check_field("more",           64'(want.more),           64'(out_if.more));
        check_field("candidate_low",  want.candidate_low,       out_if.candidate_low);
        check_field("candidate_high", 64'(want.candidate_high), 64'(out_if.candidate_high));
        check_field("visited_total",  want.visited_total,       out_if.visited_total);
        check_field("skipped_total",  want.skipped_total,       out_if.skipped_total);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one item beat; valid stays high afterwards so back-to-back beats need no
  // drop, and whoever waits on the clock next lowers it first
  task automatic send_item(logic func, logic [7:0] consumed);
    result_t r;
    bit      was_open;
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      if (in_live) begin
        in_if.valid <= 1'b0;
        in_live = 1'b0;
      end
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.func           <= func;
    in_if.bytes_consumed <= consumed;
    in_live = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);

    was_open = !walk_done;
    r = next_walk_beat(func, consumed);
    owed_results.push_back(r);
    n_items++;
    if (func == FUNC_OPEN && r.status == STATUS_INVALID) n_rejected++;
    if (func == FUNC_STEP && was_open && !r.more) n_ends++;
    if (r.skipped_total == '1) n_saturated++;
  endtask

  task automatic stop_items();
    if (in_live) begin
      in_if.valid <= 1'b0;
      in_live = 1'b0;
    end
  endtask

  // wait until every owed result is back, then let the pipe run dry
  task automatic settle();
    stop_items();
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      if (cfg_live) begin
        cfg_if.valid <= 1'b0;
        cfg_live = 1'b0;
      end
      @(posedge clk_i);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_live = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_FROZEN_LENGTH:    reg_frozen    = value[3:0];
      CFG_RANGE_LOW:        reg_low       = value[7:0];
      CFG_RANGE_HIGH:       reg_high      = value[7:0];
      CFG_WALK_DEPTH:       reg_depth     = value[3:0];
      CFG_PREFIX_HEAD_LOW:  reg_prefix_lo = value;
      CFG_PREFIX_HEAD_HIGH: reg_prefix_hi = value[55:0];
      default: ;
    endcase
  endtask

  // full register set, written only with the block idle
  task automatic write_settings(logic [3:0] frozen, logic [7:0] lo, logic [7:0] hi,
                                logic [3:0] depth, logic [63:0] pfx_lo,
                                logic [55:0] pfx_hi);
    settle();
    write_reg(CFG_FROZEN_LENGTH,    {60'd0, frozen});
    write_reg(CFG_RANGE_LOW,        {56'd0, lo});
    write_reg(CFG_RANGE_HIGH,       {56'd0, hi});
    write_reg(CFG_WALK_DEPTH,       {60'd0, depth});
    write_reg(CFG_PREFIX_HEAD_LOW,  pfx_lo);
    write_reg(CFG_PREFIX_HEAD_HIGH, {8'd0, pfx_hi});
    cfg_if.valid <= 1'b0;
    cfg_live = 1'b0;
    n_phases++;
  endtask

  // consumption mostly inside [1, depth], sometimes zero or far above
  function automatic logic [7:0] pick_consumed();
    int d, r;
    d = (walk_depth == 0) ? 1 : int'(walk_depth);
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 30) return 8'($urandom_range(255));
    if (r < 50) return 8'(d);
    return 8'($urandom_range(d, 1));
  endfunction

  // random settings, mostly valid; narrow ranges so walks reach their end
  task automatic random_settings();
    int dep, fl, lo, hi;
    dep = ($urandom_range(99) < 60) ? $urandom_range(4, 1) : $urandom_range(15, 1);
    fl  = ($urandom_range(99) < 50) ? dep - 1 : $urandom_range(dep - 1, 0);
    lo  = $urandom_range(255);
    if ($urandom_range(99) < 60) hi = (lo + $urandom_range(3) > 255) ? 255
                                                                      : lo + $urandom_range(3);
    else hi = $urandom_range(255, lo);
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: dep = 0;
        1: fl = $urandom_range(15, dep);
        default: begin
          if (lo == 0) lo = $urandom_range(255, 1);
          hi = $urandom_range(lo - 1, 0);
        end
      endcase
    end
    write_settings(4'(fl), 8'(lo), 8'(hi), 4'(dep), {$urandom, $urandom},
                   56'({$urandom, $urandom}));
  endtask

  // open under random settings, then steps with the odd restart mixed in
  task automatic run_walk(int steps);
    int s;
    random_settings();
    send_item(FUNC_OPEN, 8'($urandom_range(255)));
    for (s = 0; s < steps; s++) begin
      if ($urandom_range(99) < 6) send_item(FUNC_OPEN, 8'($urandom_range(255)));
      else send_item(FUNC_STEP, pick_consumed());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // step before any open, then the reset settings; consumption 0 and 255
  task automatic test_reset_defaults();
    send_item(FUNC_STEP, 8'h00);
    send_item(FUNC_STEP, 8'hFF);
    send_item(FUNC_OPEN, 8'h00);
    send_item(FUNC_STEP, 8'h00);
    send_item(FUNC_STEP, 8'hFF);
    send_item(FUNC_STEP, 8'h01);
  endtask

  // each rejected open leaves the running walk going
  task automatic test_rejected_opens();
    write_settings(4'd0, 8'd0, 8'd255, 4'd0, '0, '0);      // depth zero
    send_item(FUNC_OPEN, 8'h00);
    send_item(FUNC_STEP, 8'h01);
    write_settings(4'd4, 8'd0, 8'd255, 4'd4, '1, '1);      // frozen equals depth
    send_item(FUNC_OPEN, 8'h00);
    write_settings(4'd15, 8'd0, 8'd255, 4'd4, '1, '1);     // frozen above depth
    send_item(FUNC_OPEN, 8'h00);
    write_settings(4'd0, 8'd9, 8'd8, 4'd3, '0, '0);        // low above high
    send_item(FUNC_OPEN, 8'h00);
    send_item(FUNC_STEP, 8'h02);
  endtask

  // deepest frozen head: the owned byte reaches 0xFF, then the carry runs out and ends the walk
  task automatic test_carry_out_at_head();
    write_settings(4'd14, 8'd254, 8'd255, 4'd15, '1, '1);
    send_item(FUNC_OPEN, 8'h00);
    send_item(FUNC_STEP, 8'd15);
    send_item(FUNC_STEP, 8'd0);
    send_item(FUNC_STEP, 8'd7);   // walk is over
  endtask

  // the owned byte passes range_high
  task automatic test_range_high_exit();
    write_settings(4'd3, 8'h80, 8'h80, 4'd5, 64'h5555_5555_AAAA_AAAA,
                   56'hAA_AAAA_5555_5555);
    send_item(FUNC_OPEN, 8'h00);
    send_item(FUNC_STEP, 8'd5);
    send_item(FUNC_STEP, 8'd2);
  endtask

  // skip count of a shallow point saturates, then stays pinned
  task automatic test_skip_saturation();
    write_settings(4'd0, 8'd0, 8'd255, 4'd15, '0, '0);
    send_item(FUNC_OPEN, 8'h00);
    send_item(FUNC_STEP, 8'd1);
    send_item(FUNC_STEP, 8'd1);
    send_item(FUNC_STEP, 8'd9);
    send_item(FUNC_STEP, 8'd200);
  endtask

  // byte one counts through 255 and carries into the owned byte
  task automatic test_carry_ripple();
    int s;
    write_settings(4'd0, 8'h10, 8'h10, 4'd2, {$urandom, $urandom},
                   56'({$urandom, $urandom}));
    send_item(FUNC_OPEN, 8'($urandom_range(255)));
    for (s = 0; s < 257; s++) send_item(FUNC_STEP, 8'($urandom_range(255, 2)));
  endtask

  // receiver holds off while the sender keeps pushing steps
  task automatic test_backpressure();
    int s;
    write_settings(4'd0, 8'd0, 8'd255, 4'd8, {$urandom, $urandom},
                   56'({$urandom, $urandom}));
    send_item(FUNC_OPEN, 8'h00);
    hold_request = 1'b1;
    for (s = 0; s < 48; s++) send_item(FUNC_STEP, pick_consumed());
  endtask

  // back-to-back beats on both sides
  task automatic test_no_idle_burst();
    no_idle = 1'b1;
    run_walk(75);
    run_walk(75);
    no_idle = 1'b0;
  endtask

  task automatic test_random_walks();
    int start;
    start = n_items;
    while (n_items - start < RandomItems) run_walk($urandom_range(40, 5));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_if.valid          <= 1'b0;
    in_if.func           <= FUNC_OPEN;
    in_if.bytes_consumed <= 8'd0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CFG_FROZEN_LENGTH;
    cfg_if.data          <= 64'd0;
    rst_ni               <= 1'b0;

    // shadow at its reset values
    reg_frozen    = 4'd0;
    reg_low       = 8'd0;
    reg_high      = 8'd255;
    reg_depth     = 4'd1;
    reg_prefix_lo = '0;
    reg_prefix_hi = '0;
    walk_cand     = '0;
    walk_visited  = '0;
    walk_skipped  = '0;
    walk_done     = 1'b1;
    walk_fixed    = '0;
    walk_depth    = '0;
    walk_hi       = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_rejected_opens();
    test_carry_out_at_head();
    test_range_high_exit();
    test_skip_saturation();
    test_backpressure();
    test_no_idle_burst();
    test_carry_ripple();
    test_random_walks();

    settle();

    $display("Run covered %0d items in %0d settings phases, %0d results checked.",
             n_items, n_phases, n_results);
    $display("Rejected opens %0d, walks run to their end %0d, saturated skip beats %0d.",
             n_rejected, n_ends, n_saturated);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/istw_pkg.sv
src/istw_if.sv
src/istw_cfg.sv
src/istw_step.sv
src/instruction_space_tunnel_walker.sv
src/istw_checker.sv
tb/sv/instruction_space_tunnel_walker_test.sv
